FILE: hdl/shared_array_dual_stack_assert.svh
// assertion macros shared by the dual stack rtl
// expects clk and rst_n in the scope of each use
`ifndef SHARED_ARRAY_DUAL_STACK_ASSERT_SVH
`define SHARED_ARRAY_DUAL_STACK_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SADS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SADS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sads_pkg.sv
// shared types and codes for the two-stacks-in-one-array block
// no dependencies
package sads_pkg;

    typedef logic [2:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_PUSH_ONE  = 3'd0;
    localparam op_t OP_PUSH_TWO  = 3'd1;
    localparam op_t OP_POP_ONE   = 3'd2;
    localparam op_t OP_POP_TWO   = 3'd3;
    localparam op_t OP_CLEAR_ONE = 3'd4;
    localparam op_t OP_CLEAR_TWO = 3'd5;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    localparam int EXT_BITS = 64;

    // memory request from the pointer logic
    typedef struct packed {
        logic wr;
        logic rd;
    } mem_cmd_t;

endpackage

FILE: hdl/sads_mem.sv
// single-port synchronous memory holding both stacks
// depends on sads_pkg for the request struct
module sads_mem #(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32,
    parameter int AW        = 10
) (
    input  logic                 clk,
    input  sads_pkg::mem_cmd_t   cmd,
    input  logic [AW-1:0]        addr,
    input  logic [WORD_BITS-1:0] wdata,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] store [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            store[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata_reg <= store[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/sads_ctrl.sv
// stack pointers, operation decode and result registers
// depends on sads_pkg and shared_array_dual_stack_assert.svh
`include "shared_array_dual_stack_assert.svh"

module sads_ctrl #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  sads_pkg::op_t       op,
    output sads_pkg::mem_cmd_t  cmd,
    output logic [AW-1:0]       addr,
    output logic                done,
    output logic                pop_ok,
    output sads_pkg::status_t   status,
    output logic                first_empty,
    output logic                second_empty,
    output logic                both_full
);

    localparam logic [AW-1:0] TOP_IDX = AW'(DEPTH - 1);

    logic [AW-1:0]      lower_top_reg, lower_top_next;
    logic [AW-1:0]      upper_top_reg, upper_top_next;
    logic               done_reg;
    logic               pop_ok_reg, pop_ok_next;
    sads_pkg::status_t  status_reg, status_next;
    logic               full;

    assign full = (lower_top_reg == upper_top_reg);

    always_comb
    begin
        lower_top_next = lower_top_reg;
        upper_top_next = upper_top_reg;
        status_next    = sads_pkg::STATUS_DONE;
        pop_ok_next    = 1'b0;
        cmd            = '0;
        addr           = lower_top_reg;
        case (op)
            sads_pkg::OP_PUSH_ONE:
            begin
                if (full)
                begin
                    status_next = sads_pkg::STATUS_FULL;
                end
                else
                begin
                    cmd.wr         = accept;
                    lower_top_next = lower_top_reg + 1'b1;
                end
            end
            sads_pkg::OP_PUSH_TWO:
            begin
                addr = upper_top_reg;
                if (full)
                begin
                    status_next = sads_pkg::STATUS_FULL;
                end
                else
                begin
                    cmd.wr         = accept;
                    upper_top_next = upper_top_reg - 1'b1;
                end
            end
            sads_pkg::OP_POP_ONE:
            begin
                addr = lower_top_reg - 1'b1;
                if (lower_top_reg == '0)
                begin
                    status_next = sads_pkg::STATUS_EMPTY;
                end
                else
                begin
                    cmd.rd         = accept;
                    pop_ok_next    = 1'b1;
                    lower_top_next = lower_top_reg - 1'b1;
                end
            end
            sads_pkg::OP_POP_TWO:
            begin
                addr = upper_top_reg + 1'b1;
                if (upper_top_reg == TOP_IDX)
                begin
                    status_next = sads_pkg::STATUS_EMPTY;
                end
                else
                begin
                    cmd.rd         = accept;
                    pop_ok_next    = 1'b1;
                    upper_top_next = upper_top_reg + 1'b1;
                end
            end
            sads_pkg::OP_CLEAR_ONE:
            begin
                lower_top_next = '0;
            end
            sads_pkg::OP_CLEAR_TWO:
            begin
                upper_top_next = TOP_IDX;
            end
            default:
            begin
                // unused codes leave everything alone
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_top_reg <= '0;
            upper_top_reg <= TOP_IDX;
            done_reg      <= 1'b0;
            pop_ok_reg    <= 1'b0;
            status_reg    <= sads_pkg::STATUS_DONE;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                lower_top_reg <= lower_top_next;
                upper_top_reg <= upper_top_next;
                pop_ok_reg    <= pop_ok_next;
                status_reg    <= status_next;
            end
        end
    end

    assign done         = done_reg;
    assign pop_ok       = pop_ok_reg;
    assign status       = status_reg;
    assign first_empty  = (lower_top_reg == '0);
    assign second_empty = (upper_top_reg == TOP_IDX);
    assign both_full    = full;

    `SADS_ASSERT_SAME(a_no_cross, 1'b1, lower_top_reg <= upper_top_reg,
        "stack pointers crossed")
    `SADS_ASSERT_NEXT(a_done_follows, accept, done_reg,
        "accepted item gave no result")
    `SADS_ASSERT_NEXT(a_refused_push_hold,
        accept && full && (op == sads_pkg::OP_PUSH_ONE || op == sads_pkg::OP_PUSH_TWO),
        $stable(lower_top_reg) && $stable(upper_top_reg) &&
            status_reg == sads_pkg::STATUS_FULL,
        "refused push moved a pointer")
    `SADS_ASSERT_SAME(a_pop_ok_status, done_reg && pop_ok_reg,
        status_reg == sads_pkg::STATUS_DONE,
        "good pop flagged with error status")
    `SADS_ASSERT_SAME(a_single_access, 1'b1, !(cmd.wr && cmd.rd),
        "read and write in the same cycle")

endmodule

FILE: hdl/shared_array_dual_stack.sv
// top level: two lifo stacks sharing one memory
// depends on sads_pkg, sads_mem and sads_ctrl
//
//  channel  | handshake       | data
//  ---------+-----------------+--------------------------------------------------
//  command  | start / busy    | op, push_value
//  result   | done (strobe)   | pop_value, status, first_empty, second_empty, both_full
//
// an item is taken on any edge with start high and busy low; busy never rises,
// so one item can be taken every cycle
// each result appears in the cycle after its item: the pointers are updated at
// the accepting edge and the pop read returns through the memory read register
// reset clears both pointers (stack one at zero, stack two at the top index);
// the memory itself is not cleared and needs no clearing pass
// done is high for exactly one cycle per item; the receiver cannot stall
module shared_array_dual_stack #(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] push_value,
    output logic               done,
    output logic signed [31:0] pop_value,
    output logic [1:0]         status,
    output logic               first_empty,
    output logic               second_empty,
    output logic               both_full
);

    localparam int AW = $clog2(DEPTH);

    sads_pkg::mem_cmd_t     cmd;
    logic [AW-1:0]          addr;
    logic [WORD_BITS-1:0]   wdata;
    logic [WORD_BITS-1:0]   rdata;
    logic                   pop_ok;
    logic                   accept;
    logic [sads_pkg::EXT_BITS-1:0] push_ext;
    logic [sads_pkg::EXT_BITS-1:0] pop_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // sign extension of both words to the widest supported size
    for (genvar gi = 0; gi < sads_pkg::EXT_BITS; gi++)
    begin : g_ext
        if (gi < 32)
        begin : g_push_lo
            assign push_ext[gi] = push_value[gi];
        end
        else
        begin : g_push_hi
            assign push_ext[gi] = push_value[31];
        end
        if (gi < WORD_BITS)
        begin : g_pop_lo
            assign pop_ext[gi] = rdata[gi];
        end
        else
        begin : g_pop_hi
            assign pop_ext[gi] = rdata[WORD_BITS-1];
        end
    end

    assign wdata     = push_ext[WORD_BITS-1:0];
    assign pop_value = pop_ok ? signed'(pop_ext[31:0]) : '0;

    sads_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (op),
        .cmd          (cmd),
        .addr         (addr),
        .done         (done),
        .pop_ok       (pop_ok),
        .status       (status),
        .first_empty  (first_empty),
        .second_empty (second_empty),
        .both_full    (both_full)
    );

    sads_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .cmd   (cmd),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

endmodule

FILE: verif/tb_shared_array_dual_stack.sv
// self-checking testbench for shared_array_dual_stack: directed opening ops, then random
// push, pop and clear runs checked against a behavioral model of the two stacks
// depends on sads_pkg and the shared_array_dual_stack rtl
module tb_shared_array_dual_stack;

    localparam int DEPTH       = 1024;
    localparam int WORD_BITS   = 32;
    localparam int QUIET_LIMIT = 1000;
    localparam int SHOW_LIMIT  = 10;
    localparam int NUM_OPENING = 24;

    // op codes that the block treats as no-ops
    localparam sads_pkg::op_t OP_UNUSED_A = 3'd6;
    localparam sads_pkg::op_t OP_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [31:0]       popped;
        sads_pkg::status_t status;
        logic              first_empty;
        logic              second_empty;
        logic              both_full;
    } stack_result_t;

    typedef struct packed {
        sads_pkg::op_t code;
        logic [31:0]   word;
        logic          fixed;
        stack_result_t want;
    } opening_row_t;

    typedef enum {MODE_MIX, MODE_FILL, MODE_EDGE} run_mode_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         op;
    logic signed [31:0] push_value;
    logic               done;
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic               first_empty;
    logic               second_empty;
    logic               both_full;

    // model of the shared array and both top pointers
    logic [31:0]   stack_mem [DEPTH];
    int            lower_ptr;
    int            upper_ptr;

    stack_result_t pending_results [$];
    opening_row_t  opening_ops [NUM_OPENING];
    int            mismatches;
    int            items_sent;
    int            quiet_cycles;

    shared_array_dual_stack #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .push_value   (push_value),
        .done         (done),
        .pop_value    (pop_value),
        .status       (status),
        .first_empty  (first_empty),
        .second_empty (second_empty),
        .both_full    (both_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic stack_result_t step_stacks(sads_pkg::op_t code, logic [31:0] word);
        stack_result_t r;
        logic          full;
        r        = '0;
        r.status = sads_pkg::STATUS_DONE;
        full     = (lower_ptr == upper_ptr);
        case (code)
            sads_pkg::OP_PUSH_ONE:
                if (full)
                    r.status = sads_pkg::STATUS_FULL;
                else
                begin
                    stack_mem[lower_ptr] = word;
                    lower_ptr++;
                end
            sads_pkg::OP_PUSH_TWO:
                if (full)
                    r.status = sads_pkg::STATUS_FULL;
                else
                begin
                    stack_mem[upper_ptr] = word;
                    upper_ptr--;
                end
            sads_pkg::OP_POP_ONE:
                if (lower_ptr == 0)
                    r.status = sads_pkg::STATUS_EMPTY;
                else
                begin
                    lower_ptr--;
                    r.popped = stack_mem[lower_ptr];
                end
            sads_pkg::OP_POP_TWO:
                if (upper_ptr == DEPTH - 1)
                    r.status = sads_pkg::STATUS_EMPTY;
                else
                begin
                    upper_ptr++;
                    r.popped = stack_mem[upper_ptr];
                end
            sads_pkg::OP_CLEAR_ONE: lower_ptr = 0;
            sads_pkg::OP_CLEAR_TWO: upper_ptr = DEPTH - 1;
            default: ;
        endcase
        r.first_empty  = (lower_ptr == 0);
        r.second_empty = (upper_ptr == DEPTH - 1);
        r.both_full    = (lower_ptr == upper_ptr);
        return r;
    endfunction

    function automatic sads_pkg::op_t pick_op(run_mode_t mode, int lean_one);
        int r;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL:
                if (r < 95)
                    return (int'($urandom_range(99)) < lean_one) ?
                        sads_pkg::OP_PUSH_ONE : sads_pkg::OP_PUSH_TWO;
                else
                    return r[0] ? sads_pkg::OP_POP_ONE : sads_pkg::OP_POP_TWO;
            MODE_EDGE:
                case (r % 4)
                    0: return sads_pkg::OP_PUSH_ONE;
                    1: return sads_pkg::OP_PUSH_TWO;
                    2: return sads_pkg::OP_POP_ONE;
                    default: return sads_pkg::OP_POP_TWO;
                endcase
            default:
                if (r < 40)
                    return r[0] ? sads_pkg::OP_PUSH_ONE : sads_pkg::OP_PUSH_TWO;
                else if (r < 82)
                    return r[0] ? sads_pkg::OP_POP_ONE : sads_pkg::OP_POP_TWO;
                else if (r < 92)
                    return r[0] ? sads_pkg::OP_CLEAR_ONE : sads_pkg::OP_CLEAR_TWO;
                else if (r < 94)
                    return r[0] ? OP_UNUSED_A : OP_UNUSED_B;
                else
                    return r[0] ? sads_pkg::OP_POP_ONE : sads_pkg::OP_POP_TWO;
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(19))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // drive one item and hold it until the block takes it
    task automatic send_op(sads_pkg::op_t code, logic [31:0] word, logic fixed,
                           stack_result_t want);
        stack_result_t predicted;
        // no gaps in the middle stretch of the run
        while (!(items_sent >= 500 && items_sent < 900) && $urandom_range(99) < 6)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        op         <= code;
        push_value <= word;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predicted = step_stacks(code, word);
        pending_results.push_back(fixed ? want : predicted);
        items_sent++;
    endtask

    task automatic run_random(run_mode_t mode, int count, int lean_one);
        for (int i = 0; i < count; i++)
            send_op(pick_op(mode, lean_one), pick_word(), 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        stack_result_t seen;
        stack_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            seen = '{pop_value, status, first_empty, second_empty, both_full};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected result: pop_value %h status %0d flags %b%b%b",
                             seen.popped, seen.status, seen.first_empty,
                             seen.second_empty, seen.both_full);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display({"mismatch: pop_value %h/%h status %0d/%0d ",
                                  "empty1 %b/%b empty2 %b/%b full %b/%b (exp/got)"},
                                 want.popped, seen.popped, want.status, seen.status,
                                 want.first_empty, seen.first_empty,
                                 want.second_empty, seen.second_empty,
                                 want.both_full, seen.both_full);
                end
            end
        end
    end

    // watchdog on cycles with no item and no result
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int guard;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = sads_pkg::OP_PUSH_ONE;
        push_value   = '0;
        mismatches   = 0;
        items_sent   = 0;
        quiet_cycles = 0;
        lower_ptr    = 0;
        upper_ptr    = DEPTH - 1;

        // code, word, fixed, expected {popped, status, empty1, empty2, full}
        opening_ops = '{
            '{sads_pkg::OP_POP_ONE,   32'h0000_0000, 1'b1,
              '{32'h0, sads_pkg::STATUS_EMPTY, 1'b1, 1'b1, 1'b0}},
            '{sads_pkg::OP_POP_TWO,   32'h0000_0000, 1'b1,
              '{32'h0, sads_pkg::STATUS_EMPTY, 1'b1, 1'b1, 1'b0}},
            '{sads_pkg::OP_CLEAR_ONE, 32'h0000_0000, 1'b1,
              '{32'h0, sads_pkg::STATUS_DONE,  1'b1, 1'b1, 1'b0}},
            '{sads_pkg::OP_CLEAR_TWO, 32'hffff_ffff, 1'b1,
              '{32'h0, sads_pkg::STATUS_DONE,  1'b1, 1'b1, 1'b0}},
            '{OP_UNUSED_A,            32'hffff_ffff, 1'b1,
              '{32'h0, sads_pkg::STATUS_DONE,  1'b1, 1'b1, 1'b0}},
            '{OP_UNUSED_B,            32'h0000_0000, 1'b1,
              '{32'h0, sads_pkg::STATUS_DONE,  1'b1, 1'b1, 1'b0}},
            '{sads_pkg::OP_PUSH_ONE,  32'h7fff_ffff, 1'b1,
              '{32'h0, sads_pkg::STATUS_DONE,  1'b0, 1'b1, 1'b0}},
            '{sads_pkg::OP_PUSH_TWO,  32'h8000_0000, 1'b1,
              '{32'h0, sads_pkg::STATUS_DONE,  1'b0, 1'b0, 1'b0}},
            '{sads_pkg::OP_PUSH_ONE,  32'hffff_ffff, 1'b0, '0},
            '{sads_pkg::OP_PUSH_TWO,  32'h0000_0000, 1'b0, '0},
            '{sads_pkg::OP_POP_ONE,   32'h0000_0000, 1'b0, '0},
            '{sads_pkg::OP_POP_TWO,   32'hffff_ffff, 1'b0, '0},
            '{sads_pkg::OP_POP_ONE,   32'h0000_0001, 1'b1,
              '{32'h7fff_ffff, sads_pkg::STATUS_DONE, 1'b1, 1'b0, 1'b0}},
            '{sads_pkg::OP_POP_TWO,   32'h0000_0000, 1'b1,
              '{32'h8000_0000, sads_pkg::STATUS_DONE, 1'b1, 1'b1, 1'b0}},
            '{sads_pkg::OP_POP_ONE,   32'h0000_0000, 1'b1,
              '{32'h0, sads_pkg::STATUS_EMPTY, 1'b1, 1'b1, 1'b0}},
            '{sads_pkg::OP_PUSH_ONE,  32'h5555_5555, 1'b0, '0},
            '{sads_pkg::OP_PUSH_ONE,  32'haaaa_aaaa, 1'b0, '0},
            '{sads_pkg::OP_PUSH_TWO,  32'h0000_0001, 1'b0, '0},
            '{OP_UNUSED_B,            32'h0000_0000, 1'b1,
              '{32'h0, sads_pkg::STATUS_DONE,  1'b0, 1'b0, 1'b0}},
            '{sads_pkg::OP_CLEAR_ONE, 32'h0000_0000, 1'b1,
              '{32'h0, sads_pkg::STATUS_DONE,  1'b1, 1'b0, 1'b0}},
            '{sads_pkg::OP_POP_ONE,   32'h0000_0000, 1'b1,
              '{32'h0, sads_pkg::STATUS_EMPTY, 1'b1, 1'b0, 1'b0}},
            '{sads_pkg::OP_POP_TWO,   32'h0000_0000, 1'b1,
              '{32'h0000_0001, sads_pkg::STATUS_DONE, 1'b1, 1'b1, 1'b0}},
            '{sads_pkg::OP_PUSH_TWO,  32'h1234_5678, 1'b0, '0},
            '{sads_pkg::OP_CLEAR_TWO, 32'h0000_0000, 1'b1,
              '{32'h0, sads_pkg::STATUS_DONE,  1'b1, 1'b1, 1'b0}}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_ops[i])
            send_op(opening_ops[i].code, opening_ops[i].word, opening_ops[i].fixed,
                    opening_ops[i].want);

        run_random(MODE_MIX, 200, 50);

        // push, with occasional pops, until the pointers meet, with a random split between the stacks
        guard = 0;
        while (lower_ptr != upper_ptr && guard < 4000)
        begin
            send_op(pick_op(MODE_FILL, $urandom_range(15, 85)), pick_word(), 1'b0, '0);
            guard++;
        end

        // hover at full: refused pushes mixed with pops and refills
        run_random(MODE_EDGE, 60, 50);
        run_random(MODE_MIX, 150, 50);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
